// ===== src/mean_median_stddev_engine_assert.svh =====
// Assertion helpers for the statistics engine.
`ifndef MEAN_MEDIAN_STDDEV_ENGINE_ASSERT_SVH
`define MEAN_MEDIAN_STDDEV_ENGINE_ASSERT_SVH

// same-cycle implication
`define MMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mms check failed");

// next-cycle implication
`define MMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mms check failed");

`endif

// ===== src/mms_pkg.sv =====
package mms_pkg;

	localparam int MAX_COUNT = 128;
	localparam int MARK_BITS = 8;
	localparam int ADDR_W    = $clog2(MAX_COUNT);
	localparam int CNT_W     = $clog2(MAX_COUNT + 1);
	localparam int SUM_W     = MARK_BITS + ADDR_W;
	localparam int SQ_W      = 2 * MARK_BITS + ADDR_W;
	localparam int D_W       = CNT_W + SQ_W;
	localparam int NN_W      = 2 * CNT_W;
	localparam int DIV_N     = D_W + 16;
	localparam int DI_W      = $clog2(DIV_N + 1);
	localparam int RT_W      = 16;
	localparam int SQIN_W    = 2 * RT_W;
	localparam int MB_W      = $clog2(MARK_BITS);

	localparam int MEAN_W    = 16;
	localparam int MED_W     = 9;
	localparam int STD_W     = 15;
	localparam int CNTO_W    = 8;

	typedef struct packed {
		logic load;
		logic clr;
		logic prep;
		logic div_go;
		logic div_var;
		logic sq_go;
		logic med_go;
		logic med_hi;
		logic out_ld;
	} mms_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sq_done;
		logic med_done;
	} mms_sts_t;

endpackage

// ===== src/mean_median_stddev_engine.sv =====
// Statistics engine. Marks load one per cycle into a 128-entry store while the
// sum and sum of squares run alongside. The beat flagged last starts the
// compute pass, during which in_ready is low: the mean division and the
// variance division share one restoring divider, then the square root runs,
// and each of the two middle marks is found by an 8-bit search that scans
// the store once per bit through its single read port. The result sits in
// an output register, so loading of the next set starts while it waits to
// be taken.
module mean_median_stddev_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    mark,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mms_pkg::MEAN_W-1:0]    mean_q8,
	output logic [mms_pkg::MED_W-1:0]     median_x2,
	output logic [mms_pkg::STD_W-1:0]     std_dev_q8,
	output logic [mms_pkg::CNTO_W-1:0]    count,
	output logic                          overflow
);
	import mms_pkg::*;

	mms_cmd_t cmd;
	mms_sts_t sts;

	mms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mms_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mark       (mark[MARK_BITS-1:0]),
		.mean_q8    (mean_q8),
		.median_x2  (median_x2),
		.std_dev_q8 (std_dev_q8),
		.count      (count),
		.overflow   (overflow)
	);

`include "mean_median_stddev_engine_assert.svh"

	`MMS_ASSERT_NOW(a_count_range, out_valid, count != '0)
	`MMS_ASSERT_NOW(a_std_range, out_valid, std_dev_q8 <= STD_W'(((1 << MARK_BITS) - 1) * 128))
	`MMS_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && last, !in_ready)
endmodule

// ===== src/mms_ram.sv =====
module mms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/mms_datapath.sv =====
module mms_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mms_pkg::mms_cmd_t                  cmd,
	output mms_pkg::mms_sts_t                  sts,
	input  logic [mms_pkg::MARK_BITS-1:0]      mark,
	output logic [mms_pkg::MEAN_W-1:0]         mean_q8,
	output logic [mms_pkg::MED_W-1:0]          median_x2,
	output logic [mms_pkg::STD_W-1:0]          std_dev_q8,
	output logic [mms_pkg::CNTO_W-1:0]         count,
	output logic                               overflow
);
	import mms_pkg::*;

	// set accumulation
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]      sumsq_q;
	logic                 drop_q;
	logic                 room;
	logic [2*MARK_BITS-1:0] msq;

	// products
	logic [D_W-1:0]       nsq_s1;
	logic [D_W-1:0]       ssq_s1;
	logic [NN_W-1:0]      nn_s1;

	// shared divider
	logic [DIV_N-1:0]     dq_q;
	logic [NN_W-1:0]      dr_q;
	logic [NN_W-1:0]      dd_q;
	logic [DI_W-1:0]      di_q;
	logic                 dbusy_q, ddone_q, dvar_q;
	logic [NN_W:0]        dsh;
	logic                 dge;
	logic [MEAN_W-1:0]    mean_q;

	// square root
	logic [SQIN_W-1:0]    sv_q;
	logic [RT_W-1:0]      root_q;
	logic [RT_W:0]        srem_q;
	logic [$clog2(RT_W+1)-1:0] si_q;
	logic                 sbusy_q, sdone_q;
	logic [RT_W+2:0]      sr4, strial;
	logic                 sge;

	// median select
	logic [CNT_W-1:0]     mk_q, ma_q, lt_q;
	logic [MARK_BITS-1:0] mv_q, mtry, rdata;
	logic [MB_W-1:0]      mb_q;
	logic                 mbusy_q, mdone_q, mhi_q, rv_s1, issuing;
	logic [MARK_BITS-1:0] lo_q, hi_q;

	assign room  = cnt_q < CNT_W'(MAX_COUNT);
	assign msq   = (2*MARK_BITS)'(mark) * (2*MARK_BITS)'(mark);

	mms_ram #(.WIDTH(MARK_BITS), .DEPTH(MAX_COUNT)) u_store (
		.clk   (clk),
		.we    (cmd.load && room),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (mark),
		.raddr (ma_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.clr) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.load) begin
			if (room) begin
				cnt_q   <= cnt_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(mark);
				sumsq_q <= sumsq_q + SQ_W'(msq);
			end else begin
				drop_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			nsq_s1 <= D_W'(cnt_q) * D_W'(sumsq_q);
			ssq_s1 <= D_W'(sum_q) * D_W'(sum_q);
			nn_s1  <= NN_W'(cnt_q) * NN_W'(cnt_q);
		end
	end

	// restoring divider, one quotient bit per cycle
	assign dsh = {dr_q, dq_q[DIV_N-1]};
	assign dge = dsh >= {1'b0, dd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dvar_q  <= 1'b0;
			di_q    <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_go) begin
				dbusy_q <= 1'b1;
				dvar_q  <= cmd.div_var;
				di_q    <= DI_W'(DIV_N);
			end else if (dbusy_q) begin
				di_q <= di_q - 1'b1;
				if (di_q == DI_W'(1)) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			dr_q <= '0;
			if (cmd.div_var) begin
				dq_q <= {nsq_s1 - ssq_s1, 16'b0};
				dd_q <= nn_s1;
			end else begin
				dq_q <= DIV_N'({sum_q, 8'b0});
				dd_q <= NN_W'(cnt_q);
			end
		end else if (dbusy_q) begin
			dr_q <= dge ? NN_W'(dsh - {1'b0, dd_q}) : NN_W'(dsh);
			dq_q <= {dq_q[DIV_N-2:0], dge};
		end
		if (ddone_q && !dvar_q) begin
			mean_q <= dq_q[MEAN_W-1:0];
		end
	end

	// digit-by-digit square root, two radicand bits per cycle
	assign sr4    = {srem_q, sv_q[SQIN_W-1 -: 2]};
	assign strial = (RT_W+3)'({root_q, 2'b01});
	assign sge    = sr4 >= strial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbusy_q <= 1'b0;
			sdone_q <= 1'b0;
			si_q    <= '0;
		end else begin
			sdone_q <= 1'b0;
			if (cmd.sq_go) begin
				sbusy_q <= 1'b1;
				si_q    <= ($clog2(RT_W+1))'(RT_W);
			end else if (sbusy_q) begin
				si_q <= si_q - 1'b1;
				if (si_q == ($clog2(RT_W+1))'(1)) begin
					sbusy_q <= 1'b0;
					sdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_go) begin
			sv_q   <= dq_q[SQIN_W-1:0];
			root_q <= '0;
			srem_q <= '0;
		end else if (sbusy_q) begin
			srem_q <= sge ? (RT_W+1)'(sr4 - strial) : (RT_W+1)'(sr4);
			root_q <= {root_q[RT_W-2:0], sge};
			sv_q   <= {sv_q[SQIN_W-3:0], 2'b00};
		end
	end

	// k-th smallest by bitwise search: keep a trial value while fewer than k+1
	// stored marks fall below it; one store scan per bit
	assign mtry    = mv_q | (MARK_BITS'(1) << mb_q);
	assign issuing = mbusy_q && (ma_q < cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			rv_s1   <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			rv_s1   <= issuing;
			if (cmd.med_go) begin
				mbusy_q <= 1'b1;
			end else if (mbusy_q && !issuing && !rv_s1 && mb_q == '0) begin
				mbusy_q <= 1'b0;
				mdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.med_go) begin
			mhi_q <= cmd.med_hi;
			mk_q  <= cmd.med_hi ? (cnt_q >> 1) : ((cnt_q - 1'b1) >> 1);
			mv_q  <= '0;
			mb_q  <= MB_W'(MARK_BITS - 1);
			ma_q  <= '0;
			lt_q  <= '0;
		end else if (mbusy_q) begin
			if (issuing) begin
				ma_q <= ma_q + 1'b1;
			end
			if (rv_s1) begin
				lt_q <= lt_q + CNT_W'(rdata < mtry);
			end else if (!issuing) begin
				if (lt_q <= mk_q) begin
					mv_q <= mtry;
				end
				ma_q <= '0;
				lt_q <= '0;
				if (mb_q != '0) begin
					mb_q <= mb_q - 1'b1;
				end
			end
		end
		if (mdone_q) begin
			if (mhi_q) begin
				hi_q <= mv_q;
			end else begin
				lo_q <= mv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			mean_q8    <= mean_q;
			median_x2  <= MED_W'(lo_q) + MED_W'(hi_q);
			std_dev_q8 <= root_q[STD_W-1:0];
			count      <= CNTO_W'(cnt_q);
			overflow   <= drop_q;
		end
	end

	assign sts.div_done = ddone_q;
	assign sts.sq_done  = sdone_q;
	assign sts.med_done = mdone_q;
endmodule

// ===== src/mms_ctrl.sv =====
module mms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output mms_pkg::mms_cmd_t cmd,
	input  mms_pkg::mms_sts_t sts
);
	import mms_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_PREP, ST_MEAN_GO, ST_MEAN_W, ST_VAR_GO, ST_VAR_W,
		ST_SQ_GO, ST_SQ_W, ST_LO_GO, ST_LO_W, ST_HI_GO, ST_HI_W, ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == ST_LOAD;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.load    = in_valid && in_ready;
		cmd.prep    = state_q == ST_PREP;
		cmd.div_go  = state_q == ST_MEAN_GO || state_q == ST_VAR_GO;
		cmd.div_var = state_q == ST_VAR_GO;
		cmd.sq_go   = state_q == ST_SQ_GO;
		cmd.med_go  = state_q == ST_LO_GO || state_q == ST_HI_GO;
		cmd.med_hi  = state_q == ST_HI_GO;
		cmd.out_ld  = state_q == ST_OUT && out_free;
		cmd.clr     = cmd.out_ld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD:    if (in_valid && last) state_q <= ST_PREP;
				ST_PREP:    state_q <= ST_MEAN_GO;
				ST_MEAN_GO: state_q <= ST_MEAN_W;
				ST_MEAN_W:  if (sts.div_done) state_q <= ST_VAR_GO;
				ST_VAR_GO:  state_q <= ST_VAR_W;
				ST_VAR_W:   if (sts.div_done) state_q <= ST_SQ_GO;
				ST_SQ_GO:   state_q <= ST_SQ_W;
				ST_SQ_W:    if (sts.sq_done) state_q <= ST_LO_GO;
				ST_LO_GO:   state_q <= ST_LO_W;
				ST_LO_W:    if (sts.med_done) state_q <= ST_HI_GO;
				ST_HI_GO:   state_q <= ST_HI_W;
				ST_HI_W:    if (sts.med_done) state_q <= ST_OUT;
				ST_OUT:     if (out_free) state_q <= ST_LOAD;
				default:    state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
